// ----- hdl/eoef_pkg.sv -----
// ----------------------------------------------------------------------------
// eoef_pkg: shared types and constants for the even-odd edge-flag rasterizer
// Request kinds, stream packing widths, span limits and the span clamp.
// ----------------------------------------------------------------------------
package eoef_pkg;

    // Stream payload widths (data widths in whole bytes)
    localparam int S_DATA_W = 120;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 96;
    localparam int M_USER_W = 1;
    localparam int CFG_W    = 6;

    // Request kinds carried on the input tuser
    typedef enum logic [2:0] {
        MODE_FULL     = 3'd0,
        MODE_FIRST    = 3'd1,
        MODE_LAST     = 3'd2,
        MODE_READ     = 3'd3,
        MODE_LOAD     = 3'd4,
        MODE_SPAN_RST = 3'd5
    } eoef_mode_t;

    // Supported sub-scanline counts
    localparam logic [5:0] SMP_8  = 6'd8;
    localparam logic [5:0] SMP_16 = 6'd16;
    localparam logic [5:0] SMP_32 = 6'd32;

    // Empty span markers
    localparam logic signed [15:0] SPAN_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SPAN_MIN = 16'sh8000;

    // Saturate a 32-bit pixel position into 16 bits
    function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = SPAN_MAX;
        end else if (v < -32'sd32768) begin
            r = SPAN_MIN;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/eoef_ram.sv -----
// ----------------------------------------------------------------------------
// eoef_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered (old data on a
// same-address write).
// ----------------------------------------------------------------------------
module eoef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/even_odd_edge_flag_rasterizer.sv -----
// ----------------------------------------------------------------------------
// even_odd_edge_flag_rasterizer: even-odd edge-flag coverage builder
// Steps an edge over the sub-scanlines of one pixel row, toggling one bit per
// sub-scanline in a per-pixel mask word, and tracks the touched pixel span.
// ----------------------------------------------------------------------------
// Edge request: S_IDLE, then S_STEP once per sub-scanline stepped (1..32),
//   then S_DRAIN, S_SPAN and S_DONE; straight to S_DONE when the step range
//   is empty; one mask read-modify-write per cycle, set by the single mask
//   RAM port pair with write-to-read forwarding.
// Read-clear: via S_RDWAIT; offset load, span reset, other kinds: straight to S_DONE.
// One request at a time: the input is ready again in the cycle the result
//   becomes valid.
// Reset (aresetn low, synchronous): a clearing pass over all LINE_WIDTH words
//   zeroes the mask store before the first request is taken; config is
//   accepted throughout.
// ----------------------------------------------------------------------------
module even_odd_edge_flag_rasterizer #(
    parameter int LINE_WIDTH  = 1024,
    parameter int MAX_SAMPLES = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: sample_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [eoef_pkg::CFG_W-1:0]     cfg_data,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: edge_x[31:0], edge_slope[63:32], row_bound[83:64],
    //        end_row[89:84], index[99:90], offset_value[115:100], zero pad
    input  logic [eoef_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [eoef_pkg::S_USER_W-1:0]  s_axis_tuser,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: new_x[31:0], mask_word[63:32], span_low[79:64], span_high[95:80]
    output logic [eoef_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // tuser: index_fault[0]
    output logic [eoef_pkg::M_USER_W-1:0]  m_axis_tuser
);

    import eoef_pkg::*;

    localparam int AW      = $clog2(LINE_WIDTH);
    localparam int SW      = $clog2(MAX_SAMPLES);
    localparam int OFF_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int OFF_SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STEP,
        S_DRAIN,
        S_SPAN,
        S_RDWAIT,
        S_DONE
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic signed [15:0]     span_left_reg, span_left_next;
    logic signed [15:0]     span_right_reg, span_right_next;
    logic [5:0]             sample_count_reg, sample_count_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   p1_valid_reg, p1_valid_next;
    logic                   lw_valid_reg, lw_valid_next;

    // Datapath registers
    logic [31:0]            x_reg, x_next;
    logic [31:0]            slope_reg, slope_next;
    logic [31:0]            xlast_reg, xlast_next;
    logic signed [15:0]     start_reg, start_next;
    logic [5:0]             i_reg, i_next;
    logic [5:0]             last_reg, last_next;
    logic [31:0]            word_reg, word_next;
    logic                   fault_reg, fault_next;
    logic [AW-1:0]          p1_addr_reg, p1_addr_next;
    logic [31:0]            p1_bit_reg, p1_bit_next;
    logic [AW-1:0]          lw_addr_reg, lw_addr_next;
    logic [31:0]            lw_data_reg, lw_data_next;
    logic [31:0]            out_x_reg, out_x_next;
    logic [31:0]            out_word_reg, out_word_next;
    logic signed [15:0]     out_lo_reg, out_lo_next;
    logic signed [15:0]     out_hi_reg, out_hi_next;
    logic                   out_fault_reg, out_fault_next;

    // Sample offset table, to be written by the user before use (not enforced); read one step ahead
    logic [15:0]            off_rdata;
    logic                   tbl_we;

    // Input fields
    eoef_mode_t             in_mode;
    logic signed [31:0]     in_x;
    logic [31:0]            in_slope;
    logic [19:0]            in_bound;
    logic [5:0]             in_endr;
    logic [9:0]             in_idx;
    logic [15:0]            in_off;
    logic                   accept;

    // Step datapath
    logic [5:0]             n_samp;
    logic [5:0]             first_c, last_c;
    logic [31:0]            off_fix;
    logic [31:0]            sum;
    logic signed [31:0]     pix;
    logic                   pix_ok;
    logic signed [15:0]     end_pix;
    logic signed [15:0]     lo_c, hi_c;
    logic                   idx_ok;

    // Mask RAM ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [31:0]            ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [31:0]            ram_rdata;
    logic [31:0]            mask_src;

    assign in_mode  = eoef_mode_t'(s_axis_tuser[2:0]);
    assign in_x     = s_axis_tdata[31:0];
    assign in_slope = s_axis_tdata[63:32];
    assign in_bound = s_axis_tdata[83:64];
    assign in_endr  = s_axis_tdata[89:84];
    assign in_idx   = s_axis_tdata[99:90];
    assign in_off   = s_axis_tdata[115:100];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {out_hi_reg, out_lo_reg, out_word_reg, out_x_reg};
    assign m_axis_tuser  = out_fault_reg;

    // Decode sub-scanline count and step range
    always_comb begin
        n_samp = SMP_8;
        if (sample_count_reg == SMP_16) begin
            n_samp = SMP_16;
        end else if (sample_count_reg == SMP_32) begin
            n_samp = SMP_32;
        end
        if (n_samp > 6'(MAX_SAMPLES)) begin
            n_samp = 6'(MAX_SAMPLES);
        end
        first_c = '0;
        last_c  = n_samp;
        case (in_mode)
            MODE_FIRST: begin
                first_c = in_bound[5:0] & (n_samp - 6'd1);
                last_c  = (in_endr > n_samp) ? n_samp : in_endr;
            end
            MODE_LAST: begin
                last_c = in_bound[5:0] & (n_samp - 6'd1);
            end
            default: begin
                first_c = '0;
            end
        endcase
    end

    // One sub-scanline: offset add, floor, line bound check
    assign off_fix = (32'(off_rdata) << OFF_SHL) >> OFF_SHR;
    assign sum     = x_reg + off_fix;
    assign pix     = $signed(sum) >>> FRAC_BITS;
    assign pix_ok  = !pix[31] && ($unsigned(pix) < 32'(LINE_WIDTH));
    assign idx_ok  = 32'(in_idx) < 32'(LINE_WIDTH);

    // Span end points, clamped before min and max
    assign end_pix = clamp16($signed(xlast_reg) >>> FRAC_BITS);
    assign lo_c    = (start_reg < end_pix) ? start_reg : end_pix;
    assign hi_c    = (start_reg < end_pix) ? end_pix : start_reg;

    // Forward the previous write when the same word is read back
    assign mask_src = (lw_valid_reg && (lw_addr_reg == p1_addr_reg)) ? lw_data_reg
                                                                     : ram_rdata;

    // Mask RAM port selection
    always_comb begin
        ram_raddr = (state_reg == S_STEP) ? pix[AW-1:0] : AW'(in_idx);
        ram_we    = 1'b0;
        ram_waddr = p1_addr_reg;
        ram_wdata = mask_src ^ p1_bit_reg;
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (state_reg == S_RDWAIT) begin
            ram_we    = 1'b1;
            ram_wdata = '0;
        end else if (p1_valid_reg) begin
            ram_we = 1'b1;
        end
    end

    eoef_ram #(
        .WIDTH (32),
        .DEPTH (LINE_WIDTH)
    ) u_mask_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Offset table: load on request, fetch the entry of the next step
    eoef_ram #(
        .WIDTH (16),
        .DEPTH (MAX_SAMPLES)
    ) u_off_ram (
        .clk     (aclk),
        .wr_en   (tbl_we),
        .wr_addr (in_idx[SW-1:0]),
        .wr_data (in_off),
        .rd_addr (i_next[SW-1:0]),
        .rd_data (off_rdata)
    );

    // Sequencer and next values
    always_comb begin
        state_next        = state_reg;
        m_tvalid_next     = m_tvalid_reg;
        span_left_next    = span_left_reg;
        span_right_next   = span_right_reg;
        sample_count_next = cfg_valid ? cfg_data : sample_count_reg;
        clr_next          = clr_reg;
        p1_valid_next     = 1'b0;
        lw_valid_next     = p1_valid_reg;
        lw_addr_next      = p1_addr_reg;
        lw_data_next      = ram_wdata;
        x_next            = x_reg;
        slope_next        = slope_reg;
        xlast_next        = xlast_reg;
        start_next        = start_reg;
        i_next            = i_reg;
        last_next         = last_reg;
        word_next         = word_reg;
        fault_next        = fault_reg;
        p1_addr_next      = p1_addr_reg;
        p1_bit_next       = p1_bit_reg;
        out_x_next        = out_x_reg;
        out_word_next     = out_word_reg;
        out_lo_next       = out_lo_reg;
        out_hi_next       = out_hi_reg;
        out_fault_next    = out_fault_reg;
        tbl_we            = 1'b0;

        // Drop the result once taken
        if (m_tvalid_reg && m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(LINE_WIDTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    x_next     = '0;
                    word_next  = '0;
                    fault_next = 1'b0;
                    state_next = S_DONE;
                    case (in_mode)
                        MODE_FULL, MODE_FIRST, MODE_LAST: begin
                            x_next     = in_x;
                            slope_next = in_slope;
                            i_next     = first_c;
                            last_next  = last_c;
                            start_next = clamp16(in_x >>> FRAC_BITS);
                            if (first_c < last_c) begin
                                state_next = S_STEP;
                            end
                        end
                        MODE_READ: begin
                            p1_addr_next = AW'(in_idx);
                            if (idx_ok) begin
                                state_next = S_RDWAIT;
                            end else begin
                                fault_next = 1'b1;
                            end
                        end
                        MODE_LOAD: begin
                            if (32'(in_idx) < 32'(MAX_SAMPLES)) begin
                                tbl_we = 1'b1;
                            end else begin
                                fault_next = 1'b1;
                            end
                        end
                        MODE_SPAN_RST: begin
                            span_left_next  = SPAN_MAX;
                            span_right_next = SPAN_MIN;
                        end
                        default: begin
                            fault_next = 1'b0;
                        end
                    endcase
                end
            end
            S_STEP: begin
                // Issue the read for this sub-scanline and advance x
                p1_valid_next = pix_ok;
                p1_addr_next  = pix[AW-1:0];
                p1_bit_next   = 32'd1 << i_reg[4:0];
                fault_next    = fault_reg | !pix_ok;
                xlast_next    = x_reg;
                x_next        = x_reg + slope_reg;
                i_next        = i_reg + 6'd1;
                if (i_reg + 6'd1 == last_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_SPAN;
            end
            S_SPAN: begin
                if (lo_c < span_left_reg) begin
                    span_left_next = lo_c;
                end
                if (hi_c > span_right_reg) begin
                    span_right_next = hi_c;
                end
                state_next = S_DONE;
            end
            S_RDWAIT: begin
                word_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_axis_tready) begin
                    out_x_next     = x_reg;
                    out_word_next  = word_reg;
                    out_lo_next    = span_left_reg;
                    out_hi_next    = span_right_reg;
                    out_fault_next = fault_reg;
                    m_tvalid_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            m_tvalid_reg     <= 1'b0;
            span_left_reg    <= SPAN_MAX;
            span_right_reg   <= SPAN_MIN;
            sample_count_reg <= SMP_8;
            clr_reg          <= '0;
            p1_valid_reg     <= 1'b0;
            lw_valid_reg     <= 1'b0;
            out_x_reg        <= '0;
            out_word_reg     <= '0;
            out_lo_reg       <= SPAN_MAX;
            out_hi_reg       <= SPAN_MIN;
            out_fault_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            span_left_reg    <= span_left_next;
            span_right_reg   <= span_right_next;
            sample_count_reg <= sample_count_next;
            clr_reg          <= clr_next;
            p1_valid_reg     <= p1_valid_next;
            lw_valid_reg     <= lw_valid_next;
            out_x_reg        <= out_x_next;
            out_word_reg     <= out_word_next;
            out_lo_reg       <= out_lo_next;
            out_hi_reg       <= out_hi_next;
            out_fault_reg    <= out_fault_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        slope_reg     <= slope_next;
        xlast_reg     <= xlast_next;
        start_reg     <= start_next;
        i_reg         <= i_next;
        last_reg      <= last_next;
        word_reg      <= word_next;
        fault_reg     <= fault_next;
        p1_addr_reg   <= p1_addr_next;
        p1_bit_reg    <= p1_bit_next;
        lw_addr_reg   <= lw_addr_next;
        lw_data_reg   <= lw_data_next;
    end

    // No request is taken while the mask store is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during mask clearing pass");

    // A pending mask write always targets a word inside the line
    a_write_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> (32'(p1_addr_reg) < 32'(LINE_WIDTH)))
        else $error("mask write outside the line");

    // The span is either empty or ordered
    a_span_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        ((span_left_reg == SPAN_MAX) && (span_right_reg == SPAN_MIN))
        || (span_left_reg <= span_right_reg))
        else $error("span bounds out of order");

    // The step index stays inside the range while stepping
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP) |-> (i_reg < last_reg))
        else $error("step index past end of range");

endmodule
